>>> rtl/scd_pkg.sv
// Package for the serial clock divider search.
// Holds the field widths, search limits and the slot type shared by the divider chain.
// No dependencies.
`default_nettype none

package scd_pkg;

    localparam int HZ_W           = 30;
    localparam int PRE_W          = 5;
    localparam int DIV_W          = 7;
    localparam int WORD_W         = 32;
    localparam int PROD_W         = 12;
    localparam int SUM_W          = HZ_W + 1;
    localparam int MAX_PRESCALE_D = 16;
    localparam int MAX_DIVISOR_D  = 64;
    localparam int MIN_DIVISOR    = 2;
    localparam logic [HZ_W-1:0] SRC_RESET = HZ_W'(40000000);
    localparam logic [WORD_W-1:0] BYPASS_WORD = 32'h8000_0000;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              bypass;
        logic [HZ_W-1:0]   target;
        logic [DIV_W-1:0]  n;
        logic [PRE_W-1:0]  pre;
    } slot_t;

endpackage

`default_nettype wire

>>> rtl/scd_div_cell.sv
// One restoring division cell: produces one quotient bit per beat.
// Depends on scd_pkg for the slot type.
`default_nettype none

module scd_div_cell #(
    parameter int NW = 30,
    parameter int DW = 7
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [DW-1:0]  rem_i,
    input  wire logic [NW-1:0]  dvd_i,
    input  wire logic [NW-1:0]  quo_i,
    input  wire logic [DW-1:0]  den_i,
    input  wire scd_pkg::slot_t side_i,
    output logic [DW-1:0]       rem_o,
    output logic [NW-1:0]       dvd_o,
    output logic [NW-1:0]       quo_o,
    output logic [DW-1:0]       den_o,
    output scd_pkg::slot_t      side_o
);
    import scd_pkg::*;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_i, dvd_i[NW-1]};
        diff     = shifted - {1'b0, den_i};
        ge       = (shifted >= {1'b0, den_i});
        rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_o <= '0;
        end
        else if (en)
        begin
            side_o <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_o <= rem_next;
            dvd_o <= {dvd_i[NW-2:0], 1'b0};
            quo_o <= {quo_i[NW-2:0], ge};
            den_o <= den_i;
        end
    end

endmodule

`default_nettype wire

>>> rtl/scd_div_pipe.sv
// Chain of restoring division cells, one quotient bit per cell.
// Depends on scd_pkg and scd_div_cell.
`default_nettype none

module scd_div_pipe #(
    parameter int NW = 30,
    parameter int DW = 7
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [NW-1:0]  dvd_i,
    input  wire logic [DW-1:0]  den_i,
    input  wire scd_pkg::slot_t side_i,
    output logic [NW-1:0]       quo_o,
    output scd_pkg::slot_t      side_o
);
    import scd_pkg::*;

    logic [DW-1:0] rem_w  [NW+1];
    logic [NW-1:0] dvd_w  [NW+1];
    logic [NW-1:0] quo_w  [NW+1];
    logic [DW-1:0] den_w  [NW+1];
    slot_t         side_w [NW+1];

    assign rem_w[0]  = '0;
    assign dvd_w[0]  = dvd_i;
    assign quo_w[0]  = '0;
    assign den_w[0]  = den_i;
    assign side_w[0] = side_i;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        scd_div_cell #(
            .NW(NW),
            .DW(DW)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .rem_i (rem_w[i]),
            .dvd_i (dvd_w[i]),
            .quo_i (quo_w[i]),
            .den_i (den_w[i]),
            .side_i(side_w[i]),
            .rem_o (rem_w[i+1]),
            .dvd_o (dvd_w[i+1]),
            .quo_o (quo_w[i+1]),
            .den_o (den_w[i+1]),
            .side_o(side_w[i+1])
        );
    end

    assign quo_o  = quo_w[NW];
    assign side_o = side_w[NW];

endmodule

`default_nettype wire

>>> rtl/spi_clock_divider_search_core.sv
// Serial clock divider search: top level, built on scd_pkg and scd_div_pipe.
// Throughput: one candidate divisor n = 2..64 per cycle while the chain is not held;
// a new beat is taken as the last candidate of the previous one issues.
// Each beat passes the three division chains (91 cells in all) and one output register;
// a held result holds all.
// Reset clears control state and loads the source clock with 40 MHz.
`default_nettype none

module spi_clock_divider_search_core #(
    parameter int MAX_PRESCALE = scd_pkg::MAX_PRESCALE_D,
    parameter int MAX_DIVISOR  = scd_pkg::MAX_DIVISOR_D
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         source_clock_hz_we,
    input  wire logic [scd_pkg::HZ_W-1:0]     source_clock_hz,
    input  wire logic                         target_valid,
    output logic                              target_stall,
    input  wire logic [scd_pkg::HZ_W-1:0]     target_hz,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic                              bypass,
    output logic [scd_pkg::PRE_W-1:0]         prescale,
    output logic [scd_pkg::DIV_W-1:0]         count_divisor,
    output logic [scd_pkg::WORD_W-1:0]        clock_word,
    output logic [scd_pkg::HZ_W-1:0]          effective_hz
);
    import scd_pkg::*;

    localparam logic [DIV_W-1:0] N_LAST  = DIV_W'(MAX_DIVISOR);
    localparam logic [DIV_W-1:0] N_FIRST = DIV_W'(MIN_DIVISOR);
    localparam logic [PRE_W-1:0] PRE_MAX = PRE_W'(MAX_PRESCALE);

    logic [HZ_W-1:0]  src_reg;
    logic             busy_reg, busy_next;
    logic [DIV_W-1:0] n_reg, n_next;
    logic [HZ_W-1:0]  t_reg, t_next;
    logic             byp_reg, byp_next;

    logic             advance;
    logic             accept;
    logic [HZ_W-1:0]  threshold;
    slot_t            slot_a_in, slot_a_out, slot_b_in, slot_b_out, slot_c_in, slot_c_out;
    logic [HZ_W-1:0]  quo_a;
    logic [SUM_W-1:0] num_b;
    logic [SUM_W-1:0] quo_b;
    logic [PRE_W-1:0] pre_b;
    logic [PROD_W-1:0] prod_c;
    logic [HZ_W-1:0]  quo_c;

    logic [HZ_W-1:0]  err_c;
    logic             take_c;
    logic [HZ_W-1:0]  keep_err_reg, keep_err_next;
    logic [HZ_W-1:0]  keep_eff_reg, keep_eff_next;
    logic [PRE_W-1:0] keep_pre_reg, keep_pre_next;
    logic [DIV_W-1:0] keep_n_reg, keep_n_next;
    logic             fin_valid;
    logic [PRE_W-1:0] fin_pre;
    logic [DIV_W-1:0] fin_n;
    logic [HZ_W-1:0]  fin_eff;
    logic [DIV_W-1:0] fin_nm1;
    logic [DIV_W-1:0] fin_half;

    logic             out_valid_reg;
    logic             out_bypass_reg;
    logic [PRE_W-1:0] out_pre_reg;
    logic [DIV_W-1:0] out_n_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [HZ_W-1:0]  out_eff_reg;

    // source clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= SRC_RESET;
        end
        else if (source_clock_hz_we)
        begin
            src_reg <= source_clock_hz;
        end
    end

    // hold the chain while a finished beat cannot leave
    assign fin_valid    = slot_c_out.valid && slot_c_out.last;
    assign advance      = !(fin_valid && out_valid_reg && result_stall);
    assign target_stall = !(advance && (!busy_reg || n_reg == N_LAST));
    assign accept       = target_valid && !target_stall;
    assign threshold    = {1'b0, src_reg[HZ_W-1:2], 1'b0} + {2'b00, src_reg[HZ_W-1:2]};

    // candidate sequencer
    always_comb
    begin
        busy_next = busy_reg;
        n_next    = n_reg;
        t_next    = t_reg;
        byp_next  = byp_reg;
        if (advance && busy_reg)
        begin
            if (n_reg == N_LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                n_next = n_reg + 1'b1;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            n_next    = N_FIRST;
            t_next    = target_hz;
            byp_next  = (target_hz >= threshold);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= N_FIRST;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        byp_reg <= byp_next;
    end

    always_comb
    begin
        slot_a_in        = '0;
        slot_a_in.valid  = busy_reg;
        slot_a_in.first  = (n_reg == N_FIRST);
        slot_a_in.last   = (n_reg == N_LAST);
        slot_a_in.bypass = byp_reg;
        slot_a_in.target = t_reg;
        slot_a_in.n      = n_reg;
    end

    // source / n
    scd_div_pipe #(
        .NW(HZ_W),
        .DW(DIV_W)
    ) u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .dvd_i (src_reg),
        .den_i (slot_a_in.n),
        .side_i(slot_a_in),
        .quo_o (quo_a),
        .side_o(slot_a_out)
    );

    assign num_b     = {1'b0, quo_a} + {2'b00, slot_a_out.target[HZ_W-1:1]};
    assign slot_b_in = slot_a_out;

    // rounded prescaler
    scd_div_pipe #(
        .NW(SUM_W),
        .DW(HZ_W)
    ) u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .dvd_i (num_b),
        .den_i (slot_b_in.target),
        .side_i(slot_b_in),
        .quo_o (quo_b),
        .side_o(slot_b_out)
    );

    always_comb
    begin
        if (quo_b >= SUM_W'(MAX_PRESCALE))
        begin
            pre_b = PRE_MAX;
        end
        else if (quo_b == '0)
        begin
            pre_b = PRE_W'(1);
        end
        else
        begin
            pre_b = quo_b[PRE_W-1:0];
        end
        slot_c_in     = slot_b_out;
        slot_c_in.pre = pre_b;
        prod_c        = PROD_W'(pre_b) * PROD_W'(slot_b_out.n);
    end

    // effective rate
    scd_div_pipe #(
        .NW(HZ_W),
        .DW(PROD_W)
    ) u_div_c (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .dvd_i (src_reg),
        .den_i (prod_c),
        .side_i(slot_c_in),
        .quo_o (quo_c),
        .side_o(slot_c_out)
    );

    // keep the best candidate, later n wins on ties
    always_comb
    begin
        err_c  = (quo_c >= slot_c_out.target) ? quo_c - slot_c_out.target
                                              : slot_c_out.target - quo_c;
        take_c = slot_c_out.first || (err_c <= keep_err_reg);
        keep_err_next = keep_err_reg;
        keep_eff_next = keep_eff_reg;
        keep_pre_next = keep_pre_reg;
        keep_n_next   = keep_n_reg;
        if (advance && slot_c_out.valid && take_c)
        begin
            keep_err_next = err_c;
            keep_eff_next = quo_c;
            keep_pre_next = slot_c_out.pre;
            keep_n_next   = slot_c_out.n;
        end
        fin_pre  = take_c ? slot_c_out.pre : keep_pre_reg;
        fin_n    = take_c ? slot_c_out.n   : keep_n_reg;
        fin_eff  = take_c ? quo_c          : keep_eff_reg;
        fin_nm1  = fin_n - 1'b1;
        fin_half = {1'b0, fin_n[DIV_W-1:1]} - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        keep_err_reg <= keep_err_next;
        keep_eff_reg <= keep_eff_next;
        keep_pre_reg <= keep_pre_next;
        keep_n_reg   <= keep_n_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && fin_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fin_valid)
        begin
            out_bypass_reg <= slot_c_out.bypass;
            if (slot_c_out.bypass)
            begin
                out_pre_reg  <= PRE_W'(1);
                out_n_reg    <= N_FIRST;
                out_word_reg <= BYPASS_WORD;
                out_eff_reg  <= src_reg;
            end
            else
            begin
                out_pre_reg  <= fin_pre;
                out_n_reg    <= fin_n;
                out_word_reg <= {10'b0, fin_pre[3:0] - 4'd1, fin_nm1[5:0],
                                 fin_half[5:0], fin_nm1[5:0]};
                out_eff_reg  <= fin_eff;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign bypass        = out_bypass_reg;
    assign prescale      = out_pre_reg;
    assign count_divisor = out_n_reg;
    assign clock_word    = out_word_reg;
    assign effective_hz  = out_eff_reg;

endmodule

`default_nettype wire
